@@ rtl/veg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// veg_pkg
// shared types and codes of the voice envelope generator
// ----------------------------------------------------------------------------
package veg_pkg;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned LEVEL_W   = 8;
	localparam int unsigned MASTER_W  = 4;
	localparam int unsigned MUL_A_W   = 9;
	localparam int unsigned MUL_B_W   = 8;
	localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

	// item opcodes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_RATE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_RATE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_LEVEL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TICKS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_LEVEL  = 3'd6;

	typedef enum logic [2:0] {
		PH_OFF     = 3'd0,
		PH_ARMED   = 3'd1,
		PH_ATTACK  = 3'd2,
		PH_DECAY   = 3'd3,
		PH_SUSTAIN = 3'd4,
		PH_RELEASE = 3'd5,
		PH_ECHO    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ENV,
		S_MG,
		S_GR,
		S_GL,
		S_FIN,
		S_DONE
	} seq_state_t;

endpackage : veg_pkg
`default_nettype wire

@@ rtl/veg_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// veg_cmd_if
// input word channel: opcode, note start fields and pan volumes
// ----------------------------------------------------------------------------
interface veg_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic       wave_ok;
	logic [7:0] gate_length;
	logic [7:0] right_volume;
	logic [7:0] left_volume;

	modport source (
		output valid, op, wave_ok, gate_length, right_volume, left_volume,
		input  ready
	);
	modport sink (
		input  valid, op, wave_ok, gate_length, right_volume, left_volume,
		output ready
	);
endinterface : veg_cmd_if
`default_nettype wire

@@ rtl/veg_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// veg_result_if
// result word channel: voice status, envelope and stereo gains
// ----------------------------------------------------------------------------
interface veg_result_if;
	logic       valid;
	logic       ready;
	logic       active;
	logic [2:0] env_phase;
	logic [7:0] env_level;
	logic [7:0] right_amp;
	logic [7:0] left_amp;

	modport source (
		output valid, active, env_phase, env_level, right_amp, left_amp,
		input  ready
	);
	modport sink (
		input  valid, active, env_phase, env_level, right_amp, left_amp,
		output ready
	);
endinterface : veg_result_if
`default_nettype wire

@@ rtl/veg_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// veg_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface veg_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface : veg_cfg_if
`default_nettype wire

@@ rtl/voice_envelope_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voice_envelope_generator
// attack / decay / sustain / release / echo envelope of one voice with gains
// ----------------------------------------------------------------------------
// One word on cmd gives one word on result showing the voice state after it.
// A start, stop or unused opcode goes from S_EXEC straight to S_DONE. A tick
// passes S_EXEC, then S_ENV in decay and release, then S_MG, S_GR, S_GL,
// S_FIN and S_DONE when the voice stays on; when it is or goes off it skips
// to S_FIN. A single 9x8 multiplier serves a tick up to four times in turn: the
// decay or release scaling, the master gain, then the right and left gains.
// A result that is still held on result holds the next one in S_DONE while it
// waits. cmd.ready is high only while the sequencer is idle, and a new word is
// taken while the previous result still waits on result. Configuration writes
// are always accepted and should only be made while the block is idle.
// ----------------------------------------------------------------------------
module voice_envelope_generator
	import veg_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	veg_cfg_if.sink     cfg,
	veg_cmd_if.sink     cmd,
	veg_result_if.source result
);

	seq_state_t state_q, state_d;

	// configuration
	logic [LEVEL_W-1:0]  attack_rate_q, decay_rate_q, sustain_level_q, release_rate_q;
	logic [LEVEL_W-1:0]  echo_level_q, echo_ticks_q;
	logic [MASTER_W-1:0] master_level_q;

	// voice state
	phase_t             phase_q;
	logic               stop_pending_q;
	logic [LEVEL_W-1:0] level_q, echo_count_q, gate_count_q;
	logic [LEVEL_W-1:0] gain_right_q, gain_left_q, mg_q;

	// latched word
	logic [OP_W-1:0]    op_q;
	logic               wave_ok_q;
	logic [LEVEL_W-1:0] gate_length_q, rvol_q, lvol_q;

	// result register
	logic               out_valid_q;
	logic               out_active_q;
	logic [2:0]         out_phase_q;
	logic [LEVEL_W-1:0] out_level_q, out_right_q, out_left_q;

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [LEVEL_W-1:0] env_prod;

	logic [LEVEL_W-1:0] attack_base;
	logic [LEVEL_W:0]   attack_sum;
	logic               out_free;

	assign mul_p       = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	assign env_prod    = mul_p[2*LEVEL_W-1:LEVEL_W];
	assign attack_base = (phase_q == PH_ARMED) ? '0 : level_q;
	assign attack_sum  = {1'b0, attack_base} + {1'b0, attack_rate_q};
	assign out_free    = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q != OP_TICK) begin
					state_d = S_DONE;
				end else begin
					case (phase_q)
						PH_OFF:                 state_d = S_FIN;
						PH_ARMED:               state_d = stop_pending_q ? S_FIN : S_MG;
						PH_ECHO:                state_d = (echo_count_q <= 8'd1) ? S_FIN : S_MG;
						PH_DECAY, PH_RELEASE:   state_d = S_ENV;
						default:                state_d = S_MG;
					endcase
				end
			end
			S_ENV: begin
				if (phase_q == PH_RELEASE && env_prod <= echo_level_q && echo_level_q == '0)
					state_d = S_FIN;
				else if (phase_q == PH_DECAY && env_prod <= sustain_level_q &&
				         sustain_level_q == '0 && echo_level_q == '0)
					state_d = S_FIN;
				else
					state_d = S_MG;
			end
			S_MG:   state_d = S_GR;
			S_GR:   state_d = S_GL;
			S_GL:   state_d = S_FIN;
			S_FIN:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and multiplier operands
	always_comb begin
		cmd.ready = (state_q == S_IDLE);
		cfg.ready = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_ENV: begin
				mul_a = {1'b0, level_q};
				mul_b = (phase_q == PH_DECAY) ? decay_rate_q : release_rate_q;
			end
			S_MG: begin
				mul_a = MUL_A_W'({1'b0, master_level_q}) + MUL_A_W'(1);
				mul_b = level_q;
			end
			S_GR: begin
				mul_a = {1'b0, rvol_q};
				mul_b = mg_q;
			end
			S_GL: begin
				mul_a = {1'b0, lvol_q};
				mul_b = mg_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign result.valid     = out_valid_q;
	assign result.active    = out_active_q;
	assign result.env_phase = out_phase_q;
	assign result.env_level = out_level_q;
	assign result.right_amp = out_right_q;
	assign result.left_amp  = out_left_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_rate_q   <= LEVEL_MAX;
			decay_rate_q    <= '0;
			sustain_level_q <= LEVEL_MAX;
			release_rate_q  <= '0;
			echo_level_q    <= '0;
			echo_ticks_q    <= '0;
			master_level_q  <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ATTACK_RATE:   attack_rate_q   <= cfg.data;
				CFG_DECAY_RATE:    decay_rate_q    <= cfg.data;
				CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg.data;
				CFG_RELEASE_RATE:  release_rate_q  <= cfg.data;
				CFG_ECHO_LEVEL:    echo_level_q    <= cfg.data;
				CFG_ECHO_TICKS:    echo_ticks_q    <= cfg.data;
				CFG_MASTER_LEVEL:  master_level_q  <= cfg.data[MASTER_W-1:0];
				default: ;
			endcase
		end
	end

	// word capture
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q          <= cmd.op;
			wave_ok_q     <= cmd.wave_ok;
			gate_length_q <= cmd.gate_length;
			rvol_q        <= cmd.right_volume;
			lvol_q        <= cmd.left_volume;
		end
	end

	// sequencer and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			phase_q        <= PH_OFF;
			stop_pending_q <= 1'b0;
			level_q        <= '0;
			echo_count_q   <= '0;
			gate_count_q   <= '0;
			gain_right_q   <= '0;
			gain_left_q    <= '0;
			mg_q           <= '0;
			out_valid_q    <= 1'b0;
			out_active_q   <= 1'b0;
			out_phase_q    <= '0;
			out_level_q    <= '0;
			out_right_q    <= '0;
			out_left_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && result.ready && state_q != S_DONE) out_valid_q <= 1'b0;
			case (state_q)
				S_EXEC: begin
					case (op_q)
						OP_START: begin
							level_q        <= '0;
							gain_right_q   <= '0;
							gain_left_q    <= '0;
							stop_pending_q <= 1'b0;
							echo_count_q   <= echo_ticks_q;
							gate_count_q   <= gate_length_q;
							phase_q        <= wave_ok_q ? PH_ARMED : PH_OFF;
						end
						OP_STOP: begin
							if (phase_q != PH_OFF) begin
								stop_pending_q <= 1'b1;
								if (phase_q == PH_ATTACK || phase_q == PH_DECAY ||
								    phase_q == PH_SUSTAIN)
									phase_q <= PH_RELEASE;
							end
						end
						OP_TICK: begin
							case (phase_q)
								PH_ARMED, PH_ATTACK: begin
									if (phase_q == PH_ARMED && stop_pending_q) begin
										phase_q <= PH_OFF;
									end else if (attack_sum >= {1'b0, LEVEL_MAX}) begin
										level_q <= LEVEL_MAX;
										phase_q <= PH_DECAY;
									end else begin
										level_q <= attack_sum[LEVEL_W-1:0];
										phase_q <= PH_ATTACK;
									end
								end
								PH_ECHO: begin
									echo_count_q <= echo_count_q - 8'd1;
									if (echo_count_q <= 8'd1) phase_q <= PH_OFF;
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				S_ENV: begin
					if (phase_q == PH_RELEASE) begin
						if (env_prod <= echo_level_q) begin
							if (echo_level_q == '0) begin
								phase_q <= PH_OFF;
							end else begin
								level_q <= echo_level_q;
								phase_q <= PH_ECHO;
							end
						end else begin
							level_q <= env_prod;
						end
					end else begin
						if (env_prod <= sustain_level_q) begin
							if (sustain_level_q != '0) begin
								level_q <= sustain_level_q;
								phase_q <= PH_SUSTAIN;
							end else if (echo_level_q == '0) begin
								phase_q <= PH_OFF;
							end else begin
								level_q <= echo_level_q;
								phase_q <= PH_ECHO;
							end
						end else begin
							level_q <= env_prod;
						end
					end
				end
				S_MG: mg_q         <= mul_p[LEVEL_W+3:4];
				S_GR: gain_right_q <= env_prod;
				S_GL: gain_left_q  <= env_prod;
				S_FIN: begin
					// gate countdown after the envelope step
					if (gate_count_q != '0) begin
						gate_count_q <= gate_count_q - 8'd1;
						if (gate_count_q == 8'd1 && phase_q != PH_OFF) begin
							stop_pending_q <= 1'b1;
							if (phase_q == PH_ATTACK || phase_q == PH_DECAY ||
							    phase_q == PH_SUSTAIN)
								phase_q <= PH_RELEASE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_active_q <= (phase_q != PH_OFF);
						out_phase_q  <= phase_q;
						out_level_q  <= level_q;
						out_right_q  <= gain_right_q;
						out_left_q   <= gain_left_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule : voice_envelope_generator
`default_nettype wire

@@ test/voice_envelope_generator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_envelope_generator_test
// self-checking bench for the one-voice envelope generator
// ----------------------------------------------------------------------------
// A directed table covers reset state, every opcode, stops while off or armed,
// the gate counter, sustain of zero and the echo countdown; random notes then
// follow under several register settings and three stall patterns. Every
// result word is checked field by field against a table word or envelope model.
// ----------------------------------------------------------------------------
module voice_envelope_generator_test
	import veg_pkg::*;
();

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned WORDS_PER_SETTING = 100;
	localparam int unsigned SETTINGS_PER_MODE = 3;
	localparam int unsigned DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [1:0] op;
		logic       wave_ok;
		logic [7:0] gate_length;
		logic [7:0] right_volume;
		logic [7:0] left_volume;
	} cmd_word_t;

	typedef struct packed {
		logic       active;
		logic [2:0] env_phase;
		logic [7:0] env_level;
		logic [7:0] right_amp;
		logic [7:0] left_amp;
	} voice_result_t;

	typedef struct packed {
		logic [7:0] attack_rate;
		logic [7:0] decay_rate;
		logic [7:0] sustain_level;
		logic [7:0] release_rate;
		logic [7:0] echo_level;
		logic [7:0] echo_ticks;
		logic [3:0] master_level;
	} env_settings_t;

	typedef struct {
		phase_t     phase;
		logic       stop_pending;
		logic [7:0] level;
		logic [7:0] echo_count;
		logic [7:0] gate_count;
		logic [7:0] gain_right;
		logic [7:0] gain_left;
	} voice_state_t;

	typedef struct packed {
		logic          load_echo_set;
		cmd_word_t     word;
		logic          typed;
		voice_result_t want;
	} dir_row_t;

	localparam voice_result_t SILENT = '{1'b0, PH_OFF, 8'd0, 8'd0, 8'd0};
	localparam voice_result_t ARMED_CLEAN = '{1'b1, PH_ARMED, 8'd0, 8'd0, 8'd0};
	localparam voice_result_t FULL_ATTACK = '{1'b1, PH_DECAY, 8'd255, 8'd254, 8'd254};

	localparam env_settings_t RESET_SETTINGS = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 4'd15};
	localparam env_settings_t ECHO_SET = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd40, 8'd2, 4'd0};

	logic clk = 1'b0;
	logic arst_n;

	veg_cfg_if    cfg_bus ();
	veg_cmd_if    cmd_bus ();
	veg_result_if res_bus ();

	voice_envelope_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.result (res_bus)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400_000;
		$display("== FAIL ==");
		$finish;
	end

	env_settings_t regs;
	voice_state_t  voice;
	voice_result_t envelope_due [$];
	int            mismatch_count = 0;
	int            words_seen = 0;
	int            word_gap_pct = 8;
	int            result_stall_pct = 49;

	dir_row_t directed_words [27] = '{
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b1, SILENT},
		'{1'b0, '{OP_UNUSED, 1'b1, 8'd255, 8'd0,   8'd0},   1'b1, SILENT},
		'{1'b0, '{OP_STOP,   1'b0, 8'd0,   8'd0,   8'd0},   1'b1, SILENT},
		'{1'b0, '{OP_START,  1'b0, 8'd3,   8'd0,   8'd0},   1'b1, SILENT},
		'{1'b0, '{OP_TICK,   1'b1, 8'd0,   8'd17,  8'd200}, 1'b1, SILENT},
		'{1'b0, '{OP_START,  1'b1, 8'd0,   8'd0,   8'd0},   1'b1, ARMED_CLEAN},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b1, FULL_ATTACK},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd0,   8'd255}, 1'b0, SILENT},
		'{1'b0, '{OP_STOP,   1'b0, 8'd0,   8'd0,   8'd0},   1'b0, SILENT},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd128, 8'd1},   1'b0, SILENT},
		'{1'b0, '{OP_START,  1'b1, 8'd0,   8'd0,   8'd0},   1'b1, ARMED_CLEAN},
		'{1'b0, '{OP_STOP,   1'b0, 8'd0,   8'd0,   8'd0},   1'b1, ARMED_CLEAN},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b1, SILENT},
		'{1'b0, '{OP_START,  1'b1, 8'd2,   8'd0,   8'd0},   1'b1, ARMED_CLEAN},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd0},   1'b0, SILENT},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd90,  8'd60},  1'b0, SILENT},
		'{1'b0, '{OP_START,  1'b1, 8'd1,   8'd0,   8'd0},   1'b1, ARMED_CLEAN},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b0, SILENT},
		'{1'b1, '{OP_START,  1'b1, 8'd0,   8'd0,   8'd0},   1'b1, ARMED_CLEAN},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b0, SILENT},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd200, 8'd255}, 1'b0, SILENT},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd33},  1'b0, SILENT},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b0, SILENT},
		'{1'b0, '{OP_START,  1'b1, 8'd0,   8'd0,   8'd0},   1'b1, ARMED_CLEAN},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b0, SILENT},
		'{1'b0, '{OP_STOP,   1'b0, 8'd0,   8'd0,   8'd0},   1'b0, SILENT},
		'{1'b0, '{OP_TICK,   1'b0, 8'd0,   8'd255, 8'd255}, 1'b0, SILENT}
	};

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch at result word %0d: %s got %0d want %0d",
			words_seen, what, got, want);
	endtask

	// envelope model
	function automatic void raise_stop();
		if (voice.phase == PH_OFF) return;
		voice.stop_pending = 1'b1;
		if (voice.phase == PH_ATTACK || voice.phase == PH_DECAY ||
			voice.phase == PH_SUSTAIN) begin
			voice.phase = PH_RELEASE;
		end
	endfunction

	function automatic void envelope_tick(input logic [7:0] rvol, input logic [7:0] lvol);
		logic [15:0] env;
		logic [15:0] mg;
		logic [15:0] prod;
		logic [7:0]  count_was;
		env = {8'd0, voice.level};
		if (voice.phase == PH_OFF) return;
		if (voice.phase == PH_ARMED) begin
			if (voice.stop_pending) begin
				voice.phase = PH_OFF;
				return;
			end
			voice.phase = PH_ATTACK;
			env = 16'd0;
		end
		case (voice.phase)
			PH_ECHO: begin
				count_was = voice.echo_count;
				voice.echo_count = count_was - 8'd1;
				if (count_was <= 8'd1) begin
					voice.phase = PH_OFF;
					return;
				end
			end
			PH_RELEASE: begin
				env = (env * regs.release_rate) >> 8;
				if (env <= regs.echo_level) begin
					if (regs.echo_level == 8'd0) begin
						voice.phase = PH_OFF;
						return;
					end
					env = {8'd0, regs.echo_level};
					voice.phase = PH_ECHO;
				end
			end
			PH_DECAY: begin
				env = (env * regs.decay_rate) >> 8;
				if (env <= regs.sustain_level) begin
					env = {8'd0, regs.sustain_level};
					if (env == 16'd0) begin
						if (regs.echo_level == 8'd0) begin
							voice.phase = PH_OFF;
							return;
						end
						env = {8'd0, regs.echo_level};
						voice.phase = PH_ECHO;
					end else begin
						voice.phase = PH_SUSTAIN;
					end
				end
			end
			PH_ATTACK: begin
				env = env + regs.attack_rate;
				if (env >= {8'd0, LEVEL_MAX}) begin
					env = {8'd0, LEVEL_MAX};
					voice.phase = PH_DECAY;
				end
			end
			default: ;
		endcase
		voice.level = env[7:0];
		mg = ((16'(regs.master_level) + 16'd1) * env) >> 4;
		prod = 16'(rvol) * mg;
		voice.gain_right = prod[15:8];
		prod = 16'(lvol) * mg;
		voice.gain_left = prod[15:8];
	endfunction

	function automatic voice_result_t advance_voice(input cmd_word_t w);
		voice_result_t r;
		case (w.op)
			OP_TICK: begin
				envelope_tick(w.right_volume, w.left_volume);
				if (voice.gate_count != 8'd0) begin
					voice.gate_count = voice.gate_count - 8'd1;
					if (voice.gate_count == 8'd0) raise_stop();
				end
			end
			OP_START: begin
				voice.level = 8'd0;
				voice.gain_right = 8'd0;
				voice.gain_left = 8'd0;
				voice.stop_pending = 1'b0;
				voice.echo_count = regs.echo_ticks;
				voice.gate_count = w.gate_length;
				voice.phase = w.wave_ok ? PH_ARMED : PH_OFF;
			end
			OP_STOP: raise_stop();
			default: ;
		endcase
		r.active = (voice.phase != PH_OFF);
		r.env_phase = voice.phase;
		r.env_level = voice.level;
		r.right_amp = voice.gain_right;
		r.left_amp = voice.gain_left;
		return r;
	endfunction

	function automatic env_settings_t pick_settings(input int unsigned kind);
		env_settings_t s;
		case (kind)
			0: s = '0;
			1: s = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 4'd15};
			default: begin
				s.attack_rate = 8'($urandom_range(1, 255));
				s.decay_rate = 8'($urandom_range(255));
				s.sustain_level = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
				s.release_rate = 8'($urandom_range(255));
				s.echo_level = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255));
				s.echo_ticks = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(6));
				s.master_level = 4'($urandom_range(15));
			end
		endcase
		return s;
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t   w;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 68) w.op = OP_TICK;
		else if (pick < 80) w.op = OP_START;
		else if (pick < 96) w.op = OP_STOP;
		else w.op = OP_UNUSED;
		w.wave_ok = ($urandom_range(9) != 0);
		pick = $urandom_range(9);
		if (pick < 5) w.gate_length = 8'd0;
		else if (pick < 9) w.gate_length = 8'($urandom_range(1, 12));
		else w.gate_length = 8'($urandom_range(255));
		w.right_volume = 8'($urandom_range(255));
		w.left_volume = 8'($urandom_range(255));
		return w;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		case (idx)
			CFG_ATTACK_RATE:   regs.attack_rate = value;
			CFG_DECAY_RATE:    regs.decay_rate = value;
			CFG_SUSTAIN_LEVEL: regs.sustain_level = value;
			CFG_RELEASE_RATE:  regs.release_rate = value;
			CFG_ECHO_LEVEL:    regs.echo_level = value;
			CFG_ECHO_TICKS:    regs.echo_ticks = value;
			CFG_MASTER_LEVEL:  regs.master_level = value[3:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input env_settings_t s);
		write_reg(CFG_ATTACK_RATE, s.attack_rate);
		write_reg(CFG_DECAY_RATE, s.decay_rate);
		write_reg(CFG_SUSTAIN_LEVEL, s.sustain_level);
		write_reg(CFG_RELEASE_RATE, s.release_rate);
		write_reg(CFG_ECHO_LEVEL, s.echo_level);
		write_reg(CFG_ECHO_TICKS, s.echo_ticks);
		// upper data bits are don't care for the master level
		write_reg(CFG_MASTER_LEVEL, {4'($urandom_range(15)), s.master_level});
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_word(input cmd_word_t w, input logic typed, input voice_result_t want);
		voice_result_t predicted;
		while ($urandom_range(99) < word_gap_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.op <= w.op;
		cmd_bus.wave_ok <= w.wave_ok;
		cmd_bus.gate_length <= w.gate_length;
		cmd_bus.right_volume <= w.right_volume;
		cmd_bus.left_volume <= w.left_volume;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		predicted = advance_voice(w);
		envelope_due.push_back(typed ? want : predicted);
	endtask

	// lower valid at the accepting edge, then wait for every due result and for the block to go idle
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (envelope_due.size() != 0) @(posedge clk);
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		voice_result_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				words_seen++;
				if (envelope_due.size() == 0) begin
					report_mismatch("unexpected word, active", res_bus.active, 0);
				end else begin
					want = envelope_due.pop_front();
					if (res_bus.active !== want.active)
						report_mismatch("active", res_bus.active, want.active);
					if (res_bus.env_phase !== want.env_phase)
						report_mismatch("env_phase", res_bus.env_phase, want.env_phase);
					if (res_bus.env_level !== want.env_level)
						report_mismatch("env_level", res_bus.env_level, want.env_level);
					if (res_bus.right_amp !== want.right_amp)
						report_mismatch("right_amp", res_bus.right_amp, want.right_amp);
					if (res_bus.left_amp !== want.left_amp)
						report_mismatch("left_amp", res_bus.left_amp, want.left_amp);
				end
			end
			res_bus.ready <= ($urandom_range(99) >= result_stall_pct);
		end
	end

	initial begin
		int unsigned mode;
		int unsigned setting;
		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.op <= OP_TICK;
		cmd_bus.wave_ok <= 1'b0;
		cmd_bus.gate_length <= '0;
		cmd_bus.right_volume <= '0;
		cmd_bus.left_volume <= '0;
		regs = RESET_SETTINGS;
		voice = '{PH_OFF, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i]) begin
			if (directed_words[i].load_echo_set) begin
				settle();
				load_settings(ECHO_SET);
			end
			send_word(directed_words[i].word, directed_words[i].typed, directed_words[i].want);
		end

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					word_gap_pct = 8;
					result_stall_pct = 49;
				end
				1: begin
					word_gap_pct = 49;
					result_stall_pct = 8;
				end
				default: begin
					word_gap_pct = 0;
					result_stall_pct = 0;
				end
			endcase
			for (setting = 0; setting < SETTINGS_PER_MODE; setting++) begin
				settle();
				load_settings(pick_settings(setting));
				repeat (WORDS_PER_SETTING) send_word(random_word(), 1'b0, SILENT);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule : voice_envelope_generator_test
